// ----- sv/pidc_pkg.sv -----
// pidc_pkg: widths, control codes, structs and the microcode program of the
// two-mode pid controller. No dependencies; used by every other file.
`timescale 1ns / 1ps

package pidc_pkg;

    // field widths
    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int DERIV_SCALE    = 1000;
    localparam int GAIN_W         = 16;
    localparam int LIM_W          = 23;
    localparam int PER_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 23;

    // datapath widths
    localparam int ERR_W    = DATA_WIDTH + 1;
    localparam int DIFF_W   = DATA_WIDTH + 2;
    localparam int SCALE_W  = $clog2(DERIV_SCALE + 1);
    localparam int MAG_W    = DIFF_W - 1 + SCALE_W;
    localparam int NUM_W    = MAG_W + 1;
    localparam int SLOPE_W  = NUM_W;
    localparam int DSLOPE_W = SLOPE_W + 1;
    localparam int SUM_W    = LIM_W + 1;
    localparam int MB_W     = (DSLOPE_W > SUM_W) ? DSLOPE_W : SUM_W;
    localparam int PROD_W   = GAIN_W + MB_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int DEN_W    = PER_W + 1;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int PC_W     = 4;

    localparam logic [SCALE_W-1:0] SCALE_K  = SCALE_W'(DERIV_SCALE);
    localparam logic [ACC_W-1:0]   RND_HALF =
        (GAIN_FRAC_BITS > 0) ? (ACC_W'(1) << (GAIN_FRAC_BITS - 1)) : '0;
    localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(NUM_W - 1);

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_INTEG,
        OP_DIVPREP,
        OP_DIVSTEP,
        OP_SLOPE,
        OP_MULP,
        OP_MULI,
        OP_MULD,
        OP_ADDLAST,
        OP_ROUND,
        OP_EMIT
    } t_op;

    // jump conditions; a true condition takes the target, else next
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_IN_EMPTY,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_KP,
        CFG_KI,
        CFG_KD,
        CFG_OUT_MIN,
        CFG_OUT_MAX,
        CFG_ILIMIT,
        CFG_PERIOD
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic [PC_W-1:0]  next;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic div_more;
    } t_stat;

    // program addresses
    localparam logic [PC_W-1:0] ST_ACCEPT  = 4'd0;
    localparam logic [PC_W-1:0] ST_INTEG   = 4'd1;
    localparam logic [PC_W-1:0] ST_DIVPREP = 4'd2;
    localparam logic [PC_W-1:0] ST_DIVSTEP = 4'd3;
    localparam logic [PC_W-1:0] ST_SLOPE   = 4'd4;
    localparam logic [PC_W-1:0] ST_MULP    = 4'd5;
    localparam logic [PC_W-1:0] ST_MULI    = 4'd6;
    localparam logic [PC_W-1:0] ST_MULD    = 4'd7;
    localparam logic [PC_W-1:0] ST_ADDLAST = 4'd8;
    localparam logic [PC_W-1:0] ST_ROUND   = 4'd9;
    localparam logic [PC_W-1:0] ST_EMIT    = 4'd10;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target,
                                  input logic [PC_W-1:0] next);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.next   = next;
        return w;
    endfunction

    // microcode rom
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            ST_ACCEPT:  w = uw(OP_ACCEPT,  COND_IN_EMPTY, ST_ACCEPT,  ST_INTEG);
            ST_INTEG:   w = uw(OP_INTEG,   COND_NEVER,    ST_ACCEPT,  ST_DIVPREP);
            ST_DIVPREP: w = uw(OP_DIVPREP, COND_NEVER,    ST_ACCEPT,  ST_DIVSTEP);
            ST_DIVSTEP: w = uw(OP_DIVSTEP, COND_DIV_MORE, ST_DIVSTEP, ST_SLOPE);
            ST_SLOPE:   w = uw(OP_SLOPE,   COND_NEVER,    ST_ACCEPT,  ST_MULP);
            ST_MULP:    w = uw(OP_MULP,    COND_NEVER,    ST_ACCEPT,  ST_MULI);
            ST_MULI:    w = uw(OP_MULI,    COND_NEVER,    ST_ACCEPT,  ST_MULD);
            ST_MULD:    w = uw(OP_MULD,    COND_NEVER,    ST_ACCEPT,  ST_ADDLAST);
            ST_ADDLAST: w = uw(OP_ADDLAST, COND_NEVER,    ST_ACCEPT,  ST_ROUND);
            ST_ROUND:   w = uw(OP_ROUND,   COND_NEVER,    ST_ACCEPT,  ST_EMIT);
            ST_EMIT:    w = uw(OP_EMIT,    COND_OUT_BUSY, ST_EMIT,    ST_ACCEPT);
            default:    w = uw(OP_NOP,     COND_NEVER,    ST_ACCEPT,  ST_ACCEPT);
        endcase
        return w;
    endfunction

endpackage

// ----- sv/pidc_ifs.sv -----
// pidc_ifs: valid/ready channel interfaces for sample beats and drive beats.
// Depends on pidc_pkg for the data width.
`timescale 1ns / 1ps

interface pidc_in_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [pidc_pkg::DATA_WIDTH-1:0]      setpoint;
    logic signed [pidc_pkg::DATA_WIDTH-1:0]      measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

interface pidc_out_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [pidc_pkg::DATA_WIDTH-1:0]      drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// ----- sv/pidc_seq.sv -----
// pidc_seq: microcode sequencer, step counter plus rom lookup and jumps.
// Depends on pidc_pkg (program, control word and status structs).
`timescale 1ns / 1ps

module pidc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pidc_pkg::t_stat    i_stat,
    output pidc_pkg::t_uword   o_word
);

    logic [pidc_pkg::PC_W-1:0] r_pc;
    logic [pidc_pkg::PC_W-1:0] n_pc;
    pidc_pkg::t_uword          w_word;
    logic                      w_take;

    // current control word
    assign w_word = pidc_pkg::ucode(r_pc);
    assign o_word = w_word;

    // jump condition
    always_comb begin
        case (w_word.cond)
            pidc_pkg::COND_NEVER:    w_take = 1'b0;
            pidc_pkg::COND_IN_EMPTY: w_take = !i_stat.in_valid;
            pidc_pkg::COND_DIV_MORE: w_take = i_stat.div_more;
            pidc_pkg::COND_OUT_BUSY: w_take = i_stat.out_busy;
            default:                 w_take = 1'b0;
        endcase
    end

    assign n_pc = w_take ? w_word.target : w_word.next;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pidc_pkg::ST_ACCEPT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- sv/pid_controller_two_mode.sv -----
// pid_controller_two_mode: top level, config registers, controller state and
// the shared datapath (adder, serial divider, one multiplier) under pidc_seq.
// Depends on pidc_pkg, pidc_ifs and pidc_seq.
//
//  channel   dir  beat                    handshake
//  i_sample  in   setpoint, measurement   valid/ready
//  o_result  out  drive                   valid/ready
//  i_cfg_*   in   index, data             write enable, no wait
//
// Each sample runs through these steps in order: accept,
// integral update, divider setup, a 28-step restoring divide for the
// derivative (one quotient bit a cycle), then three passes of the shared
// multiplier, rounding and output. The divide makes up most of the run.
// Synchronous active-low reset restores the register defaults and clears state.
// A full output register stalls the program at its last step only.
`timescale 1ns / 1ps

module pid_controller_two_mode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pidc_in_if.sink                            i_sample,
    pidc_out_if.source                         o_result,
    input  logic                               i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DW     = pidc_pkg::DATA_WIDTH;
    localparam int ERR_W  = pidc_pkg::ERR_W;
    localparam int DIFF_W = pidc_pkg::DIFF_W;
    localparam int MAG_W  = pidc_pkg::MAG_W;
    localparam int NUM_W  = pidc_pkg::NUM_W;
    localparam int SLP_W  = pidc_pkg::SLOPE_W;
    localparam int DSL_W  = pidc_pkg::DSLOPE_W;
    localparam int SUM_W  = pidc_pkg::SUM_W;
    localparam int MB_W   = pidc_pkg::MB_W;
    localparam int PROD_W = pidc_pkg::PROD_W;
    localparam int ACC_W  = pidc_pkg::ACC_W;
    localparam int DEN_W  = pidc_pkg::DEN_W;
    localparam int CNT_W  = pidc_pkg::CNT_W;
    localparam int GW     = pidc_pkg::GAIN_W;
    localparam int LIM_W  = pidc_pkg::LIM_W;
    localparam int PER_W  = pidc_pkg::PER_W;

    // configuration registers
    logic                     r_mode;
    logic signed [GW-1:0]     r_kp;
    logic signed [GW-1:0]     r_ki;
    logic signed [GW-1:0]     r_kd;
    logic signed [GW-1:0]     r_out_min;
    logic signed [GW-1:0]     r_out_max;
    logic [LIM_W-1:0]         r_ilimit;
    logic [PER_W-1:0]         r_period;

    // controller state
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SLP_W-1:0]  r_prev_slope;

    // working registers
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_rem;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [SLP_W-1:0]  r_slope;
    logic signed [DSL_W-1:0]  r_dslope;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DW-1:0]     r_drive;
    logic                     r_out_valid;

    pidc_pkg::t_uword         w_word;
    pidc_pkg::t_stat          w_stat;
    logic                     w_in_fire;
    logic                     w_out_busy;
    logic                     w_emit;
    logic                     w_gain_wr;

    logic signed [ERR_W-1:0]  w_err_in;
    logic signed [SUM_W:0]    w_sum_raw;
    logic signed [SUM_W:0]    w_lim;
    logic signed [SUM_W-1:0]  w_sum_new;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_abs_diff;
    logic [MAG_W-1:0]         w_scaled;
    logic [NUM_W-1:0]         w_num0;
    logic [PER_W-1:0]         w_period;
    logic [DEN_W-1:0]         w_den;
    logic [DEN_W:0]           w_rem_sh;
    logic [DEN_W:0]           w_rem_sub;
    logic                     w_ge;
    logic signed [SLP_W-1:0]  w_slope;
    logic signed [GW-1:0]     w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         w_acc_mag;
    logic [ACC_W-1:0]         w_rnd;
    logic signed [ACC_W-1:0]  w_y;
    logic signed [ACC_W-1:0]  w_lo;
    logic signed [ACC_W-1:0]  w_hi;
    logic signed [ACC_W-1:0]  w_y_lo;
    logic signed [ACC_W-1:0]  w_y_cl;

    // sequencer
    pidc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_word  (w_word)
    );

    // handshakes
    assign i_sample.ready = (w_word.op == pidc_pkg::OP_ACCEPT);
    assign w_in_fire      = i_sample.valid && i_sample.ready;
    assign w_out_busy     = r_out_valid && !o_result.ready;
    assign w_emit         = (w_word.op == pidc_pkg::OP_EMIT) && !w_out_busy;
    assign o_result.valid = r_out_valid;
    assign o_result.drive = r_drive;

    assign w_stat.in_valid = i_sample.valid;
    assign w_stat.out_busy = w_out_busy;
    assign w_stat.div_more = (r_cnt != '0);

    assign w_gain_wr = i_cfg_we && ((i_cfg_idx == pidc_pkg::CFG_KP) ||
                                    (i_cfg_idx == pidc_pkg::CFG_KI) ||
                                    (i_cfg_idx == pidc_pkg::CFG_KD));

    // error and clamped integral
    assign w_err_in  = ERR_W'(i_sample.setpoint) - ERR_W'(i_sample.measurement);
    assign w_sum_raw = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_err);
    assign w_lim     = $signed({2'b00, r_ilimit});
    always_comb begin
        if (w_sum_raw < -w_lim) begin
            w_sum_new = SUM_W'(-w_lim);
        end else if (w_sum_raw > w_lim) begin
            w_sum_new = SUM_W'(w_lim);
        end else begin
            w_sum_new = SUM_W'(w_sum_raw);
        end
    end
    assign w_diff = DIFF_W'(r_err) - DIFF_W'(r_prev_err);

    // divider setup: numerator 2*|diff|*scale + period, denominator 2*period
    assign w_period   = (r_period == '0) ? PER_W'(1) : r_period;
    assign w_den      = {w_period, 1'b0};
    assign w_abs_diff = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign w_scaled   = MAG_W'(w_abs_diff[DIFF_W-2:0]) * MAG_W'(pidc_pkg::SCALE_K);
    assign w_num0     = {w_scaled, 1'b0} + NUM_W'(w_period);

    // one restoring divide step
    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_den});
    assign w_rem_sub = w_rem_sh - {1'b0, w_den};
    assign w_slope   = r_neg ? -$signed(r_num) : $signed(r_num);

    // shared multiplier operands
    always_comb begin
        case (w_word.op)
            pidc_pkg::OP_MULP: begin
                w_mul_a = r_kp;
                w_mul_b = r_mode ? MB_W'(r_diff) : MB_W'(r_err);
            end
            pidc_pkg::OP_MULI: begin
                w_mul_a = r_ki;
                w_mul_b = r_mode ? MB_W'(r_err) : MB_W'(r_sum);
            end
            default: begin
                w_mul_a = r_kd;
                w_mul_b = r_mode ? MB_W'(r_dslope) : MB_W'(r_slope);
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // round to nearest, halves away from zero
    assign w_acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_rnd     = (w_acc_mag + pidc_pkg::RND_HALF) >> pidc_pkg::GAIN_FRAC_BITS;
    assign w_y       = r_acc[ACC_W-1] ? -$signed(w_rnd) : $signed(w_rnd);

    // output limits, low bound first
    assign w_lo   = ACC_W'(r_out_min);
    assign w_hi   = ACC_W'(r_out_max);
    assign w_y_lo = (r_acc < w_lo) ? w_lo : r_acc;
    assign w_y_cl = (w_y_lo > w_hi) ? w_hi : w_y_lo;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_kp      <= GW'(256);
            r_ki      <= '0;
            r_kd      <= '0;
            r_out_min <= {1'b1, {(GW - 1){1'b0}}};
            r_out_max <= {1'b0, {(GW - 1){1'b1}}};
            r_ilimit  <= LIM_W'(65535);
            r_period  <= PER_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pidc_pkg::CFG_MODE:    r_mode    <= i_cfg_data[0];
                pidc_pkg::CFG_KP:      r_kp      <= i_cfg_data[GW-1:0];
                pidc_pkg::CFG_KI:      r_ki      <= i_cfg_data[GW-1:0];
                pidc_pkg::CFG_KD:      r_kd      <= i_cfg_data[GW-1:0];
                pidc_pkg::CFG_OUT_MIN: r_out_min <= i_cfg_data[GW-1:0];
                pidc_pkg::CFG_OUT_MAX: r_out_max <= i_cfg_data[GW-1:0];
                pidc_pkg::CFG_ILIMIT:  r_ilimit  <= i_cfg_data[LIM_W-1:0];
                pidc_pkg::CFG_PERIOD:  r_period  <= i_cfg_data[PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller state, cleared by any gain write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_gain_wr) begin
            r_prev_err   <= '0;
            r_sum        <= '0;
            r_prev_slope <= '0;
        end else begin
            if (w_word.op == pidc_pkg::OP_INTEG) begin
                r_sum <= w_sum_new;
            end
            if (w_emit) begin
                r_prev_err   <= r_err;
                r_prev_slope <= r_slope;
            end
        end
    end

    // divide step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_word.op == pidc_pkg::OP_DIVPREP) begin
                r_cnt <= pidc_pkg::DIV_LAST;
            end else if ((w_word.op == pidc_pkg::OP_DIVSTEP) && (r_cnt != '0)) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (w_word.op)
            pidc_pkg::OP_ACCEPT: begin
                if (w_in_fire) begin
                    r_err <= w_err_in;
                end
            end
            pidc_pkg::OP_INTEG: begin
                r_diff <= w_diff;
            end
            pidc_pkg::OP_DIVPREP: begin
                r_num <= w_num0;
                r_rem <= '0;
                r_neg <= r_diff[DIFF_W-1];
            end
            pidc_pkg::OP_DIVSTEP: begin
                r_rem <= w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], w_ge};
            end
            pidc_pkg::OP_SLOPE: begin
                r_slope <= w_slope;
            end
            pidc_pkg::OP_MULP: begin
                r_dslope <= DSL_W'(r_slope) - DSL_W'(r_prev_slope);
                r_prod   <= w_prod;
                r_acc    <= '0;
            end
            pidc_pkg::OP_MULI, pidc_pkg::OP_MULD: begin
                r_prod <= w_prod;
                r_acc  <= r_acc + ACC_W'(r_prod);
            end
            pidc_pkg::OP_ADDLAST: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            pidc_pkg::OP_ROUND: begin
                r_acc <= w_y;
            end
            pidc_pkg::OP_EMIT: begin
                if (w_emit) begin
                    r_drive <= w_y_cl[DW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_then_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (w_word.op == pidc_pkg::OP_INTEG))
        else $error("accepted sample not followed by integral step");

    a_integral_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_word.op == pidc_pkg::OP_INTEG) |=>
            (((SUM_W + 1)'(r_sum) <= w_lim) && ((SUM_W + 1)'(r_sum) >= -w_lim)))
        else $error("integral outside its limit");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_word.op == pidc_pkg::OP_DIVSTEP) |=> (r_rem < w_den))
        else $error("divider remainder not below denominator");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (o_result.valid && (w_word.op == pidc_pkg::OP_ACCEPT)))
        else $error("drive beat not presented or program not back at accept");
`endif

endmodule

// ----- dv/pid_controller_two_mode_tb.sv -----
// pid_controller_two_mode_tb: self-checking bench for the two-mode pid controller.
// Uses pidc_pkg, pidc_ifs and the pid_controller_two_mode top level; nothing else.
`timescale 1ns / 1ps

module pid_controller_two_mode_tb;

    localparam int DATA_WIDTH     = pidc_pkg::DATA_WIDTH;
    localparam int CFG_DATA_W     = pidc_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W      = pidc_pkg::CFG_IDX_W;
    localparam int DERIV_SCALE    = pidc_pkg::DERIV_SCALE;
    localparam int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int PHASES         = 12;
    localparam int TAIL_CYCLES    = 60;

    typedef enum bit {
        ROW_SAMPLE,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                     kind;
        pidc_pkg::t_cfg_idx            idx;
        logic [CFG_DATA_W-1:0]         data;
        logic signed [DATA_WIDTH-1:0]  sp;
        logic signed [DATA_WIDTH-1:0]  ms;
        bit                            typed;
        logic signed [DATA_WIDTH-1:0]  want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pidc_in_if  smp ();
    pidc_out_if res ();

    pid_controller_two_mode u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // register shadow, reset values
    bit     mode_incr   = 1'b0;
    longint gain_p      = 256;
    longint gain_i      = 0;
    longint gain_d      = 0;
    longint drive_lo    = -32768;
    longint drive_hi    = 32767;
    longint integ_lim   = 65535;
    longint period_ms   = 10;

    // controller state shadow
    longint last_err     = 0;
    longint err_integral = 0;
    longint last_slope   = 0;

    logic signed [DATA_WIDTH-1:0] drive_due [$];
    logic signed [DATA_WIDTH-1:0] drive_seen_want;
    t_row plan [$];

    bit no_idle     = 1'b0;
    int n_fail      = 0;
    int n_samples   = 0;
    int n_results   = 0;
    int n_cfg       = 0;
    int idle_cycles = 0;

    // next drive value for one sample; advances the state shadow
    function automatic logic signed [DATA_WIDTH-1:0] pid_next_drive(
        input logic signed [DATA_WIDTH-1:0] sp,
        input logic signed [DATA_WIDTH-1:0] ms
    );
        longint err, per, num, mag, slope, acc, y;
        err = longint'(sp) - longint'(ms);
        per = (period_ms == 0) ? 1 : period_ms;

        // clamped integral
        err_integral = err_integral + err;
        if (err_integral < -integ_lim)
            err_integral = -integ_lim;
        else if (err_integral > integ_lim)
            err_integral = integ_lim;

        // derivative, nearest with halves away from zero
        num   = (err - last_err) * DERIV_SCALE;
        mag   = (num < 0) ? -num : num;
        mag   = (2 * mag + per) / (2 * per);
        slope = (num < 0) ? -mag : mag;

        if (!mode_incr)
            acc = gain_p * err + gain_i * err_integral + gain_d * slope;
        else
            acc = gain_p * (err - last_err) + gain_i * err + gain_d * (slope - last_slope);

        // drop gain fraction bits, halves away from zero
        mag = (acc < 0) ? -acc : acc;
        if (GAIN_FRAC_BITS > 0)
            mag = (mag + (longint'(1) << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
        y = (acc < 0) ? -mag : mag;

        // raise to the floor first, then cap
        if (y < drive_lo)
            y = drive_lo;
        if (y > drive_hi)
            y = drive_hi;

        last_err   = err;
        last_slope = slope;
        return y[DATA_WIDTH-1:0];
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // register value with random upper bits, often at an extreme
    function automatic logic [CFG_DATA_W-1:0] cfg_pick(input pidc_pkg::t_cfg_idx idx);
        logic [CFG_DATA_W-1:0] d;
        int r;
        d = CFG_DATA_W'($urandom);
        r = $urandom_range(0, 99);
        case (idx)
            pidc_pkg::CFG_KP, pidc_pkg::CFG_KI, pidc_pkg::CFG_KD: begin
                if (r < 6)
                    d[15:0] = 16'h8000;
                else if (r < 12)
                    d[15:0] = 16'h7fff;
                else if (r < 18)
                    d[15:0] = '0;
                else if (r < 70)
                    d[15:0] = 16'(int'($urandom_range(0, 1536)) - 768);
            end
            pidc_pkg::CFG_OUT_MIN: begin
                if (r < 20)
                    d[15:0] = 16'h8000;
                else if (r < 80)
                    d[15:0] = 16'(-int'($urandom_range(0, 30000)));
            end
            pidc_pkg::CFG_OUT_MAX: begin
                if (r < 20)
                    d[15:0] = 16'h7fff;
                else if (r < 80)
                    d[15:0] = 16'($urandom_range(0, 30000));
            end
            pidc_pkg::CFG_ILIMIT: begin
                if (r < 10)
                    d = '0;
                else if (r < 20)
                    d = 23'h7fffff;
                else if (r < 60)
                    d = 23'($urandom_range(0, 3000));
            end
            pidc_pkg::CFG_PERIOD: begin
                if (r < 5)
                    d[9:0] = '0;
                else if (r < 10)
                    d[9:0] = 10'h3ff;
                else if (r < 20)
                    d[9:0] = 10'd1000;
                else if (r < 30)
                    d[9:0] = 10'd1;
                else
                    d[9:0] = 10'($urandom_range(1, 1000));
            end
            default: ;
        endcase
        return d;
    endfunction

    function automatic void plan_smp(input int sp, input int ms, input bit typed,
                                     input int want);
        t_row row;
        row.kind  = ROW_SAMPLE;
        row.idx   = pidc_pkg::CFG_MODE;
        row.data  = '0;
        row.sp    = 16'(sp);
        row.ms    = 16'(ms);
        row.typed = typed;
        row.want  = 16'(want);
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(input pidc_pkg::t_cfg_idx idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.sp    = '0;
        row.ms    = '0;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    // one register write, then the shadow follows
    task automatic cfg_write(input pidc_pkg::t_cfg_idx idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            pidc_pkg::CFG_MODE:    mode_incr = data[0];
            pidc_pkg::CFG_KP:      gain_p    = longint'($signed(data[15:0]));
            pidc_pkg::CFG_KI:      gain_i    = longint'($signed(data[15:0]));
            pidc_pkg::CFG_KD:      gain_d    = longint'($signed(data[15:0]));
            pidc_pkg::CFG_OUT_MIN: drive_lo  = longint'($signed(data[15:0]));
            pidc_pkg::CFG_OUT_MAX: drive_hi  = longint'($signed(data[15:0]));
            pidc_pkg::CFG_ILIMIT:  integ_lim = longint'(data[22:0]);
            pidc_pkg::CFG_PERIOD:  period_ms = longint'(data[9:0]);
            default: ;
        endcase
        // any gain write wipes the controller history
        if (idx == pidc_pkg::CFG_KP || idx == pidc_pkg::CFG_KI ||
            idx == pidc_pkg::CFG_KD) begin
            last_err     = 0;
            err_integral = 0;
            last_slope   = 0;
        end
        n_cfg++;
    endtask

    // one sample beat, optional lead-in gap; expectation queued at acceptance
    task automatic put_sample(input logic signed [DATA_WIDTH-1:0] sp,
                              input logic signed [DATA_WIDTH-1:0] ms,
                              input bit typed,
                              input logic signed [DATA_WIDTH-1:0] want);
        int gap;
        logic signed [DATA_WIDTH-1:0] predicted;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp.valid       <= 1'b1;
        smp.setpoint    <= sp;
        smp.measurement <= ms;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        predicted = pid_next_drive(sp, ms);
        drive_due.push_back(typed ? want : predicted);
        n_samples++;
    endtask

    // drop valid and wait for every outstanding drive beat
    task automatic settle();
        @(negedge i_clk);
        smp.valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge i_clk);
    endtask

    // drive beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            n_results++;
            if (drive_due.size() == 0) begin
                n_fail++;
                $error("drive: expected nothing, got %0d", res.drive);
            end else begin
                drive_seen_want = drive_due.pop_front();
                if (res.drive !== drive_seen_want) begin
                    n_fail++;
                    $error("drive: expected %0d, got %0d", drive_seen_want, res.drive);
                end
            end
        end
    end

    // watchdog on cycles without any beat or write
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp.valid && smp.ready) || (res.valid && res.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles with no beat, %0d drive beats still due",
                     idle_cycles, drive_due.size());
            $display("** pid_controller_two_mode: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // drive side back-pressure: bursts of ready, random stalls
    initial begin : sink_pacing
        int burst;
        int stall;
        res.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            res.ready <= 1'b1;
            burst = $urandom_range(1, 24);
            repeat (burst - 1) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                res.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int k;
        int r;
        int sp_track;
        int ms_track;
        t_row row;

        smp.valid       = 1'b0;
        smp.setpoint    = '0;
        smp.measurement = '0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains: unit kp, full output range
        plan_smp(32767, -32768, 1, 32767);
        plan_smp(-32768, 32767, 1, -32768);
        plan_smp(0, 0, 1, 0);
        plan_smp(100, 40, 1, 60);
        plan_smp(-5, 0, 1, -5);
        // inverted output limits land on out_max
        plan_cfg(pidc_pkg::CFG_OUT_MIN, 23'h000064);
        plan_cfg(pidc_pkg::CFG_OUT_MAX, 23'h00ff9c);
        plan_smp(0, 0, 1, -100);
        plan_smp(5000, 0, 1, -100);
        plan_cfg(pidc_pkg::CFG_OUT_MIN, 23'h008000);
        plan_cfg(pidc_pkg::CFG_OUT_MAX, 23'h007fff);
        // gain extremes and half-way rounding
        plan_cfg(pidc_pkg::CFG_KP, 23'h008000);
        plan_smp(1, 0, 1, -128);
        plan_cfg(pidc_pkg::CFG_KP, 23'h007fff);
        plan_smp(0, 1, 1, -128);
        plan_cfg(pidc_pkg::CFG_KP, 23'h000080);
        plan_smp(1, 0, 1, 1);
        plan_smp(0, 1, 1, -1);
        plan_smp(3, 0, 1, 2);
        // all three terms, zero period treated as one
        plan_cfg(pidc_pkg::CFG_KP, 23'h000100);
        plan_cfg(pidc_pkg::CFG_KI, 23'h000100);
        plan_cfg(pidc_pkg::CFG_KD, 23'h008000);
        plan_cfg(pidc_pkg::CFG_PERIOD, 23'h000000);
        plan_smp(1000, 0, 0, 0);
        plan_smp(-2000, 0, 0, 0);
        plan_cfg(pidc_pkg::CFG_PERIOD, 23'h0003e8);
        plan_smp(300, 0, 0, 0);
        // wide integral, then limit dropped under it
        plan_cfg(pidc_pkg::CFG_ILIMIT, 23'h7fffff);
        plan_cfg(pidc_pkg::CFG_KD, 23'h007fff);
        plan_smp(32767, -32768, 0, 0);
        plan_smp(32767, -32768, 0, 0);
        plan_smp(-32768, 32767, 0, 0);
        plan_cfg(pidc_pkg::CFG_ILIMIT, 23'h00000a);
        plan_smp(0, 0, 0, 0);
        plan_cfg(pidc_pkg::CFG_ILIMIT, 23'h000000);
        plan_smp(7, 0, 0, 0);
        // incremental form
        plan_cfg(pidc_pkg::CFG_MODE, 23'h000001);
        plan_smp(100, 0, 0, 0);
        plan_smp(-100, 0, 0, 0);
        plan_smp(32767, -32768, 0, 0);
        plan_smp(-32768, 32767, 0, 0);
        plan_cfg(pidc_pkg::CFG_PERIOD, 23'h000001);
        plan_smp(0, 0, 0, 0);
        plan_cfg(pidc_pkg::CFG_MODE, 23'h000000);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                settle();
                cfg_write(row.idx, row.data);
            end else begin
                put_sample(row.sp, row.ms, row.typed, row.want);
            end
        end

        // random phases: new settings, then a tracking loop with some noise
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            no_idle = (phase % 4 == 3);
            for (k = 0; k < 8; k++) begin
                if ($urandom_range(0, 99) < 40)
                    cfg_write(pidc_pkg::t_cfg_idx'(k), cfg_pick(pidc_pkg::t_cfg_idx'(k)));
            end
            sp_track = int'($urandom_range(0, 65535)) - 32768;
            ms_track = int'($urandom_range(0, 65535)) - 32768;
            repeat (RANDOM_ITEMS / PHASES) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    sp_track = int'($urandom_range(0, 65535)) - 32768;
                if (r >= 8 && r < 20) begin
                    put_sample(16'($urandom), 16'($urandom), 1'b0, '0);
                end else begin
                    ms_track = ms_track + (sp_track - ms_track) / 4
                               + int'($urandom_range(0, 64)) - 32;
                    if (ms_track > 32767)
                        ms_track = 32767;
                    if (ms_track < -32768)
                        ms_track = -32768;
                    put_sample(16'(sp_track), 16'(ms_track), 1'b0, '0);
                end
            end
        end
        no_idle = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d samples, %0d drive beats checked, %0d register writes",
                 n_samples, n_results, n_cfg);
        $display("run: directed extremes and rounding, then %0d random phases in both modes",
                 PHASES);
        if (n_fail == 0)
            $display("** pid_controller_two_mode: PASSED **");
        else
            $display("** pid_controller_two_mode: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pidc_pkg.sv
sv/pidc_ifs.sv
sv/pidc_seq.sv
sv/pid_controller_two_mode.sv
dv/pid_controller_two_mode_tb.sv
